@@ rtl/vector_to_polar_defines.svh @@
// Assertion macros for the vector-to-polar RTL.
`ifndef VECTOR_TO_POLAR_DEFINES_SVH
`define VECTOR_TO_POLAR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define V2P_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define V2P_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/v2p_pkg.sv @@
// Shared constants, tables and types of the vector-to-polar block.
package v2p_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned LEN_W      = COORD_W + 1;
  localparam int unsigned CORDIC_W   = 64;
  localparam int unsigned NORM_MSB   = 59;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned STEPS      = 32;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned ROOT_STEPS = DIFF_W;
  localparam int unsigned REM_W      = LEN_W + 1;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned IDX_W      = 5;

  // Quadrant codes, counterclockwise from +x.
  localparam logic [1:0] QUAD_NE = 2'd0;
  localparam logic [1:0] QUAD_NW = 2'd1;
  localparam logic [1:0] QUAD_SW = 2'd2;
  localparam logic [1:0] QUAD_SE = 2'd3;

  // Arctangent of 2^-i, 2^32 units per turn, rounded to nearest.
  localparam logic [Z_W-1:0] ATAN_TAB [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [CORDIC_W-1:0] x;
    logic [CORDIC_W-1:0] y;
    logic [Z_W-1:0]      z;
    logic [1:0]          quad;
    logic                zero;
  } stage_t;

  typedef struct packed {
    logic [LEN_W-1:0] root;
    logic [REM_W-1:0] rem;
  } root_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [LEN_W-1:0]   length;
  } res_t;

endpackage

@@ rtl/v2p_if.sv @@
// Valid/ready channel interfaces for the vector-to-polar block.
interface v2p_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [v2p_pkg::COORD_W-1:0] tail_x;
  logic signed [v2p_pkg::COORD_W-1:0] tail_y;
  logic signed [v2p_pkg::COORD_W-1:0] head_x;
  logic signed [v2p_pkg::COORD_W-1:0] head_y;

  modport source (output valid, output tail_x, output tail_y, output head_x,
                  output head_y, input ready);
  modport sink (input valid, input tail_x, input tail_y, input head_x,
                input head_y, output ready);
endinterface

interface v2p_out_if;
  logic                         valid;
  logic                         ready;
  logic [v2p_pkg::ANGLE_W-1:0] angle;
  logic [v2p_pkg::LEN_W-1:0]   length;

  modport source (output valid, output angle, output length, input ready);
  modport sink (input valid, input angle, input length, output ready);
endinterface

@@ rtl/v2p_front.sv @@
// Front end: difference, quadrant fold, squares and CORDIC operand normalization.
module v2p_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [v2p_pkg::COORD_W-1:0] tail_x_i,
  input  logic signed [v2p_pkg::COORD_W-1:0] tail_y_i,
  input  logic signed [v2p_pkg::COORD_W-1:0] head_x_i,
  input  logic signed [v2p_pkg::COORD_W-1:0] head_y_i,
  output logic                               valid_o,
  output v2p_pkg::stage_t                    vec_o,
  output logic [v2p_pkg::SQ_W-1:0]           sq_o
);

  logic signed [v2p_pkg::DIFF_W-1:0] dx, dy;
  logic [v2p_pkg::DIFF_W-1:0]        ax, ay;
  logic [1:0]                        quad;
  logic                              straight;

  logic                              valid_a_q;
  logic [v2p_pkg::DIFF_W-1:0]        adj_a_q, adj_a_d;
  logic [v2p_pkg::DIFF_W-1:0]        opp_a_q, opp_a_d;
  logic [1:0]                        quad_a_q;

  logic [v2p_pkg::DIFF_W-1:0]        big;
  logic [v2p_pkg::IDX_W-1:0]         msb_idx;
  logic [v2p_pkg::SHIFT_W-1:0]       shift;
  logic [v2p_pkg::SQ_W-1:0]          p_adj, p_opp;

  logic                              valid_b_q;
  v2p_pkg::stage_t                   vec_b_q, vec_b_d;
  logic [v2p_pkg::SQ_W-1:0]          sq_b_q, sq_b_d;

  // Stage A: exact differences, magnitudes and the quadrant.
  always_comb begin
    dx = v2p_pkg::DIFF_W'(head_x_i) - v2p_pkg::DIFF_W'(tail_x_i);
    dy = v2p_pkg::DIFF_W'(head_y_i) - v2p_pkg::DIFF_W'(tail_y_i);
    ax = dx[v2p_pkg::DIFF_W-1] ? v2p_pkg::DIFF_W'(-dx) : v2p_pkg::DIFF_W'(dx);
    ay = dy[v2p_pkg::DIFF_W-1] ? v2p_pkg::DIFF_W'(-dy) : v2p_pkg::DIFF_W'(dy);
    if (!dy[v2p_pkg::DIFF_W-1]) begin
      quad = dx[v2p_pkg::DIFF_W-1] ? v2p_pkg::QUAD_NW : v2p_pkg::QUAD_NE;
    end else begin
      quad = dx[v2p_pkg::DIFF_W-1] ? v2p_pkg::QUAD_SW : v2p_pkg::QUAD_SE;
    end
    // In the first and third quadrants x is the adjacent side; otherwise y is.
    straight = (quad == v2p_pkg::QUAD_NE) || (quad == v2p_pkg::QUAD_SW);
    adj_a_d  = straight ? ax : ay;
    opp_a_d  = straight ? ay : ax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adj_a_q  <= adj_a_d;
      opp_a_q  <= opp_a_d;
      quad_a_q <= quad;
      vec_b_q  <= vec_b_d;
      sq_b_q   <= sq_b_d;
    end
  end

  // Stage B: shift both sides so the larger one tops out at NORM_MSB; sum the squares.
  always_comb begin
    big     = (adj_a_q > opp_a_q) ? adj_a_q : opp_a_q;
    msb_idx = '0;
    for (int b = 0; b < v2p_pkg::DIFF_W; b++) begin
      if (big[b]) begin
        msb_idx = v2p_pkg::IDX_W'(b);
      end
    end
    shift = v2p_pkg::SHIFT_W'(v2p_pkg::NORM_MSB) - v2p_pkg::SHIFT_W'(msb_idx);

    vec_b_d.x    = v2p_pkg::CORDIC_W'(adj_a_q) << shift;
    vec_b_d.y    = v2p_pkg::CORDIC_W'(opp_a_q) << shift;
    vec_b_d.z    = '0;
    vec_b_d.quad = quad_a_q;
    vec_b_d.zero = (big == '0);

    p_adj  = v2p_pkg::SQ_W'(adj_a_q) * v2p_pkg::SQ_W'(adj_a_q);
    p_opp  = v2p_pkg::SQ_W'(opp_a_q) * v2p_pkg::SQ_W'(opp_a_q);
    sq_b_d = p_adj + p_opp;
  end

  assign valid_o = valid_b_q;
  assign vec_o   = vec_b_q;
  assign sq_o    = sq_b_q;

endmodule

@@ rtl/v2p_cordic.sv @@
// Vectoring CORDIC, one iteration per pipeline stage.
module v2p_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  v2p_pkg::stage_t vec_i,
  output logic            valid_o,
  output v2p_pkg::stage_t vec_o
);

  logic [v2p_pkg::STEPS-1:0] valid_q;
  v2p_pkg::stage_t           stg_q [v2p_pkg::STEPS];

  for (genvar k = 0; k < v2p_pkg::STEPS; k++) begin : g_step
    v2p_pkg::stage_t                   prev, nxt;
    logic                              prev_valid;
    logic signed [v2p_pkg::CORDIC_W-1:0] xs, ys;

    if (k == 0) begin : g_first
      assign prev       = vec_i;
      assign prev_valid = valid_i;
    end else begin : g_next
      assign prev       = stg_q[k-1];
      assign prev_valid = valid_q[k-1];
    end

    always_comb begin
      xs       = $signed(prev.x) >>> k;
      ys       = $signed(prev.y) >>> k;
      nxt      = prev;
      // Rotate toward the x axis; the sign of y picks the direction.
      if (!prev.y[v2p_pkg::CORDIC_W-1]) begin
        nxt.x = prev.x + v2p_pkg::CORDIC_W'(ys);
        nxt.y = prev.y - v2p_pkg::CORDIC_W'(xs);
        nxt.z = prev.z + v2p_pkg::ATAN_TAB[k];
      end else begin
        nxt.x = prev.x - v2p_pkg::CORDIC_W'(ys);
        nxt.y = prev.y + v2p_pkg::CORDIC_W'(xs);
        nxt.z = prev.z - v2p_pkg::ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign valid_o = valid_q[v2p_pkg::STEPS-1];
  assign vec_o   = stg_q[v2p_pkg::STEPS-1];

endmodule

@@ rtl/v2p_sqrt.sv @@
// Digit-by-digit square root, one root bit per stage, padded to the CORDIC depth.
module v2p_sqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [v2p_pkg::SQ_W-1:0] sq_i,
  output v2p_pkg::root_t           rt_o
);

  v2p_pkg::root_t           rt_q  [v2p_pkg::STEPS];
  logic [v2p_pkg::SQ_W-1:0] rad_q [v2p_pkg::ROOT_STEPS-1];

  for (genvar k = 0; k < v2p_pkg::STEPS; k++) begin : g_step
    v2p_pkg::root_t rt_prev, rt_nxt;

    if (k == 0) begin : g_first
      assign rt_prev = '0;
    end else begin : g_next
      assign rt_prev = rt_q[k-1];
    end

    if (k < v2p_pkg::ROOT_STEPS) begin : g_digit
      logic [v2p_pkg::SQ_W-1:0]    rad_prev;
      logic [v2p_pkg::REM_W+1:0]   rem_t, trial;
      logic                        ge;

      if (k == 0) begin : g_rad_first
        assign rad_prev = sq_i;
      end else begin : g_rad_next
        assign rad_prev = rad_q[k-1];
      end

      always_comb begin
        rem_t  = {rt_prev.rem, rad_prev[v2p_pkg::SQ_W-1 -: 2]};
        trial  = {1'b0, rt_prev.root, 2'b01};
        ge     = (rem_t >= trial);
        rt_nxt.rem  = ge ? v2p_pkg::REM_W'(rem_t - trial) : v2p_pkg::REM_W'(rem_t);
        rt_nxt.root = {rt_prev.root[v2p_pkg::LEN_W-2:0], ge};
      end

      if (k < v2p_pkg::ROOT_STEPS - 1) begin : g_rad
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rad_q[k] <= rad_prev << 2;
          end
        end
      end
    end else begin : g_delay
      assign rt_nxt = rt_prev;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[k] <= rt_nxt;
      end
    end
  end

  assign rt_o = rt_q[v2p_pkg::STEPS-1];

endmodule

@@ rtl/v2p_out_stage.sv @@
// Result rounding and the two-entry output buffer that decouples the stall.
`include "vector_to_polar_defines.svh"

module v2p_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  v2p_pkg::stage_t             vec_i,
  input  v2p_pkg::root_t              rt_i,
  output logic                        en_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [v2p_pkg::ANGLE_W-1:0] angle_o,
  output logic [v2p_pkg::LEN_W-1:0]   length_o
);

  logic                   en, take;
  logic [v2p_pkg::Z_W-1:0] z_sum;
  logic                   round_up;
  v2p_pkg::res_t          res_d;
  v2p_pkg::res_t          out_q, skid_q;
  logic                   out_valid_q, out_valid_d;
  logic                   skid_valid_q, skid_valid_d;
  logic                   load_out, load_skid, from_skid;

  assign en   = !skid_valid_q;
  assign take = valid_i && en;

  always_comb begin
    // Add the quarter turns and half an output unit, then keep the top bits.
    z_sum = vec_i.z + (v2p_pkg::Z_W'(vec_i.quad) << (v2p_pkg::Z_W - 2))
          + (v2p_pkg::Z_W'(1) << (v2p_pkg::Z_W - v2p_pkg::ANGLE_W - 1));
    res_d.angle  = vec_i.zero ? '0 : z_sum[v2p_pkg::Z_W-1 -: v2p_pkg::ANGLE_W];
    round_up     = (rt_i.rem > v2p_pkg::REM_W'(rt_i.root));
    res_d.length = rt_i.root + v2p_pkg::LEN_W'(round_up);
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    from_skid    = 1'b0;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
        load_out     = 1'b1;
        from_skid    = 1'b1;
      end else begin
        out_valid_d = take;
        load_out    = take;
      end
    end else if (take) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= from_skid ? skid_q : res_d;
    end
    if (load_skid) begin
      skid_q <= res_d;
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_valid_q;
  assign angle_o     = out_q.angle;
  assign length_o    = out_q.length;

  `V2P_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry without output entry")
  `V2P_ASSERT_NXT(a_stall_to_skid, take && out_valid_q && !out_ready_i, skid_valid_q, "stalled result not parked")
  `V2P_ASSERT_IMP(a_len_zero_vec, valid_i, (res_d.length == '0) == vec_i.zero, "length and zero flag disagree")

endmodule

@@ rtl/vector_to_polar.sv @@
// Top level of the vector-to-polar block: tail/head points in, angle and length out.
//
// Usage: each transfer on in_i carries one vector as its tail and head points
// (signed Q8.8). Each produces exactly one transfer on out_o with the direction
// as a binary angle (65536 units per turn, counterclockwise from +x) and the
// Euclidean length in unsigned Q9.8, both rounded to nearest. A zero vector
// gives angle 0 and length 0.
// Throughput: one item per clock cycle while the output buffer has room. Every
// stage is a register stage, so new items enter while earlier ones are in flight.
// Pipeline: from the input transfer to the output transfer an item passes
// through two front-end stages, 32 CORDIC iteration stages (the square root runs
// alongside them in 17 digit stages plus delay), and the output register. The
// CORDIC iteration count sets this depth.
// Reset clears all valid bits; no result is shown until an item has passed
// through. When the receiver stalls, the result moves into a second output
// entry; once that entry is full, in_i.ready drops and the whole pipeline
// holds, so nothing is lost or repeated.
module vector_to_polar (
  input logic       clk_i,
  input logic       rst_ni,
  v2p_in_if.sink    in_i,
  v2p_out_if.source out_o
);

  logic            en;
  logic            front_valid;
  v2p_pkg::stage_t front_vec;
  logic [v2p_pkg::SQ_W-1:0] front_sq;
  logic            cordic_valid;
  v2p_pkg::stage_t cordic_vec;
  v2p_pkg::root_t  root;

  // The pipeline advances whenever the output buffer has room; its ready is
  // registered, so no combinational path runs from out_o.ready to in_i.ready.
  assign in_i.ready = en;

  v2p_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .tail_x_i (in_i.tail_x),
    .tail_y_i (in_i.tail_y),
    .head_x_i (in_i.head_x),
    .head_y_i (in_i.head_y),
    .valid_o  (front_valid),
    .vec_o    (front_vec),
    .sq_o     (front_sq)
  );

  // Angle within the folded quadrant.
  v2p_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .vec_i   (front_vec),
    .valid_o (cordic_valid),
    .vec_o   (cordic_vec)
  );

  // Square root of dx^2 + dy^2; same depth and enable as the CORDIC, so it
  // stays aligned with the valid bits carried there.
  v2p_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .sq_i  (front_sq),
    .rt_o  (root)
  );

  v2p_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cordic_valid),
    .vec_i       (cordic_vec),
    .rt_i        (root),
    .en_o        (en),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .angle_o     (out_o.angle),
    .length_o    (out_o.length)
  );

endmodule

@@ tb/tb_vector_to_polar.sv @@
// Self-checking testbench for vector_to_polar: directed and random vectors against a polar predictor.
`timescale 1ns / 1ps

module tb_vector_to_polar;

  typedef logic signed [v2p_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t tail_x;
    coord_t tail_y;
    coord_t head_x;
    coord_t head_y;
  } vec_t;

  typedef struct packed {
    logic [v2p_pkg::ANGLE_W-1:0] angle;
    logic [v2p_pkg::LEN_W-1:0]   length;
  } polar_t;

  // A directed row either carries a hand-written result or leaves it to the predictor.
  typedef struct packed {
    vec_t   vec;
    logic   typed;
    polar_t want;
  } row_t;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned PIPE_LATENCY  = 35;
  localparam int unsigned SETTLE_CYCLES = 2 * PIPE_LATENCY;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned PHASE_ITEMS   = 650;
  localparam int unsigned MAX_REPORTS   = 50;

  // The angle accumulator counts 2^32 units per turn; the output keeps the top bits.
  localparam int unsigned TURN_BITS  = 32;
  localparam int unsigned ROUND_DROP = TURN_BITS - v2p_pkg::ANGLE_W;
  localparam int unsigned NORM_TOP   = 59;
  localparam int unsigned ITERATIONS = 32;

  // Arctangent of 2^-i in turn units, rounded to nearest, entry 0 first.
  localparam logic [32*32-1:0] ARCTAN_LUT = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  localparam coord_t C_MIN = -32768;
  localparam coord_t C_MAX = 32767;

  // Binary angles of the four axis directions and the longest axis-aligned length.
  localparam logic [v2p_pkg::ANGLE_W-1:0] ANG_EAST  = 16'd0;
  localparam logic [v2p_pkg::ANGLE_W-1:0] ANG_NORTH = 16'd16384;
  localparam logic [v2p_pkg::ANGLE_W-1:0] ANG_WEST  = 16'd32768;
  localparam logic [v2p_pkg::ANGLE_W-1:0] ANG_SOUTH = 16'd49152;
  localparam logic [v2p_pkg::LEN_W-1:0]   LEN_AXIS  = 17'd65535;

  localparam int unsigned NUM_ROWS = 24;

  logic clk_i;
  logic rst_ni;

  v2p_in_if  in_if ();
  v2p_out_if out_if ();

  vector_to_polar u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  polar_t      expected_polar [$];
  int unsigned fail_count     = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // Directed vectors: zero vectors, axis extremes, the wrap at a full turn,
  // single-LSB vectors, the longest diagonals in every quadrant and a few patterns.
  row_t directed_rows [NUM_ROWS] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0},   1'b1, '{ANG_EAST, 17'd0}},
    '{'{C_MIN, C_MAX, C_MIN, C_MAX},       1'b1, '{ANG_EAST, 17'd0}},
    '{'{C_MAX, C_MIN, C_MAX, C_MIN},       1'b1, '{ANG_EAST, 17'd0}},
    '{'{C_MIN, 16'sd0, C_MAX, 16'sd0},     1'b1, '{ANG_EAST, LEN_AXIS}},
    '{'{C_MAX, 16'sd0, C_MIN, 16'sd0},     1'b1, '{ANG_WEST, LEN_AXIS}},
    '{'{16'sd0, C_MIN, 16'sd0, C_MAX},     1'b1, '{ANG_NORTH, LEN_AXIS}},
    '{'{16'sd0, C_MAX, 16'sd0, C_MIN},     1'b1, '{ANG_SOUTH, LEN_AXIS}},
    '{'{C_MIN, 16'sd1, C_MAX, 16'sd0},     1'b1, '{ANG_EAST, LEN_AXIS}},
    '{'{C_MIN, 16'sd0, C_MAX, 16'sd1},     1'b1, '{ANG_EAST, LEN_AXIS}},
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0},   1'b1, '{ANG_EAST, 17'd1}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1},   1'b1, '{ANG_NORTH, 17'd1}},
    '{'{16'sd0, 16'sd0, -16'sd1, 16'sd0},  1'b1, '{ANG_WEST, 17'd1}},
    '{'{16'sd0, 16'sd0, 16'sd0, -16'sd1},  1'b1, '{ANG_SOUTH, 17'd1}},
    '{'{C_MIN, C_MIN, C_MAX, C_MAX},       1'b0, '0},
    '{'{C_MAX, C_MAX, C_MIN, C_MIN},       1'b0, '0},
    '{'{C_MAX, C_MIN, C_MIN, C_MAX},       1'b0, '0},
    '{'{C_MIN, C_MAX, C_MAX, C_MIN},       1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd256, 16'sd256},    1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd256, 16'sd256},   1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd256, -16'sd256},  1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd256, -16'sd256},   1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd768, 16'sd1024},   1'b0, '0},
    '{'{16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd1},        1'b0, '0}
  };

  // Free-running clock, 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Works out direction and length of one vector the way the block should:
  // exact differences, quadrant from the signs, vectoring rotation inside the
  // quadrant, and a square root rounded to nearest.
  function automatic polar_t predict_polar(input vec_t v);
    longint             dx;
    longint             dy;
    longint unsigned    ax;
    longint unsigned    ay;
    longint unsigned    sum_sq;
    longint unsigned    root;
    longint unsigned    trial;
    longint unsigned    adj;
    longint unsigned    opp;
    longint unsigned    big;
    longint unsigned    z;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic [1:0]         quad;
    int unsigned        shift;
    polar_t             res;

    dx = longint'(v.head_x) - longint'(v.tail_x);
    dy = longint'(v.head_y) - longint'(v.tail_y);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;

    // Bit-by-bit integer root, then one up when the remainder exceeds the root.
    sum_sq = ax * ax + ay * ay;
    root   = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    if (sum_sq - root * root > root) root = root + 1;
    res.length = root[v2p_pkg::LEN_W-1:0];

    if (dy >= 0) quad = (dx >= 0) ? v2p_pkg::QUAD_NE : v2p_pkg::QUAD_NW;
    else         quad = (dx < 0)  ? v2p_pkg::QUAD_SW : v2p_pkg::QUAD_SE;

    res.angle = '0;
    if (ax != 0 || ay != 0) begin
      // In the odd quadrants the roles of the two legs swap.
      if (quad == v2p_pkg::QUAD_NE || quad == v2p_pkg::QUAD_SW) begin
        adj = ax;
        opp = ay;
      end else begin
        adj = ay;
        opp = ax;
      end
      big   = (adj > opp) ? adj : opp;
      shift = 0;
      while (big < (64'd1 << NORM_TOP)) begin
        big   = big << 1;
        shift = shift + 1;
      end
      cx = adj << shift;
      cy = opp << shift;
      z  = 0;
      for (int i = 0; i < ITERATIONS; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (!cy[63]) begin
          cx = cx + sy;
          cy = cy - sx;
          z  = z + ARCTAN_LUT[(31 - i) * 32 +: 32];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          z  = z - ARCTAN_LUT[(31 - i) * 32 +: 32];
        end
      end
      // Add the quarter turns, wrap to one turn, then round half up; a round-up
      // to a full turn falls off the top and leaves zero.
      z = (z + (64'(quad) << (TURN_BITS - 2))) & 64'hFFFF_FFFF;
      z = (z + (64'd1 << (ROUND_DROP - 1))) >> ROUND_DROP;
      res.angle = z[v2p_pkg::ANGLE_W-1:0];
    end
    return res;
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      4:       return C_MAX;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Half uniform points, half short vectors, near-axis vectors and corner
  // coordinates, so that the wrap and the small-length cases recur.
  function automatic vec_t random_vector();
    int unsigned pick;
    vec_t        v;

    pick     = $urandom_range(0, 99);
    v.tail_x = coord_t'($urandom);
    v.tail_y = coord_t'($urandom);
    v.head_x = coord_t'($urandom);
    v.head_y = coord_t'($urandom);
    if (pick < 20) begin
      v.head_x = v.tail_x + coord_t'($urandom_range(0, 64)) - coord_t'(32);
      v.head_y = v.tail_y + coord_t'($urandom_range(0, 64)) - coord_t'(32);
    end else if (pick < 35) begin
      if ($urandom_range(0, 1) == 0)
        v.head_y = v.tail_y + coord_t'($urandom_range(0, 2)) - coord_t'(1);
      else
        v.head_x = v.tail_x + coord_t'($urandom_range(0, 2)) - coord_t'(1);
    end else if (pick < 50) begin
      v.tail_x = corner_coord();
      v.tail_y = corner_coord();
      v.head_x = corner_coord();
      v.head_y = corner_coord();
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Presents one vector and holds it until the transfer; the expected result is
  // queued at the edge that accepts it. Valid stays high between back-to-back
  // vectors, so each step sees at most one assignment to it.
  task automatic send_vector(input vec_t v, input logic typed, input polar_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.tail_x <= v.tail_x;
    in_if.tail_y <= v.tail_y;
    in_if.head_x <= v.head_x;
    in_if.head_y <= v.head_y;
    do @(posedge clk_i); while (!in_if.ready);
    expected_polar.push_back(typed ? want : predict_polar(v));
  endtask

  // Stops sending and waits until every queued result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_polar.size() != 0);
  endtask

  // Result side: checks each transfer against the oldest expectation and
  // picks the ready level for the next edge.
  initial begin
    polar_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_polar.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending: angle %0d length %0d",
                                    results_seen, out_if.angle, out_if.length));
        end else begin
          want = expected_polar.pop_front();
          if (out_if.angle !== want.angle)
            report_mismatch($sformatf("result %0d angle %0d, expected %0d",
                                      results_seen, out_if.angle, want.angle));
          if (out_if.length !== want.length)
            report_mismatch($sformatf("result %0d length %0d, expected %0d",
                                      results_seen, out_if.length, want.length));
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog: a run that overshoots the limit has lost or stuck a result.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_if.valid  <= 1'b0;
    in_if.tail_x <= '0;
    in_if.tail_y <= '0;
    in_if.head_x <= '0;
    in_if.head_y <= '0;
    rst_ni       <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++)
      send_vector(directed_rows[r].vec, directed_rows[r].typed, directed_rows[r].want);
    // Let the pipeline run completely dry once before the random traffic.
    drain_results();

    // Three phases: a slow receiver, then a slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 10; sink_stall_pct = 77; end
        1:       begin src_idle_pct = 77; sink_stall_pct = 10; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_vector(random_vector(), 1'b0, '0);
      if (phase == 0) drain_results();
    end

    drain_results();
    // Any extra result the block still emits shows up within this window.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/v2p_pkg.sv
rtl/v2p_if.sv
rtl/v2p_front.sv
rtl/v2p_cordic.sv
rtl/v2p_sqrt.sv
rtl/v2p_out_stage.sv
rtl/vector_to_polar.sv
tb/tb_vector_to_polar.sv
